FILE: hw/rtl/lbh_pkg.sv
// Package for the latency bucket histogram: beat structs, operation codes
// and the fixed bucket bounds in nanoseconds.
// Depends on nothing; used by every module in hw/rtl.
package lbh_pkg;

  // Operation codes carried in the request beat.
  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  // The spare code behaves as a read.
  localparam logic [1:0] OP_SPARE   = 2'd3;

  // Number of finite upper bounds in the bound table.
  localparam int unsigned BOUND_COUNT = 11;

  // Finite upper bounds; a sample equal to a bound falls in that bucket.
  localparam logic [63:0] BOUND_NS [BOUND_COUNT] = '{
    64'd100000,
    64'd250000,
    64'd500000,
    64'd1000000,
    64'd2500000,
    64'd5000000,
    64'd10000000,
    64'd25000000,
    64'd50000000,
    64'd100000000,
    64'd250000000
  };

  // Request beat.
  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] latency_ns;
    logic [3:0]  bucket_index;
  } req_t;

  // Result beat.
  typedef struct packed {
    logic [3:0]  bucket_hit;
    logic [63:0] bucket_count;
    logic [63:0] cumulative_count;
    logic [63:0] total_sum;
    logic [63:0] total_count;
  } res_t;

  // Control of the registered request as it reaches the counter bank.
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
  } ctl_t;

  // Upper bound of bucket i; buckets past the table take the largest value.
  function automatic logic [63:0] bound_of(input int unsigned i);
    logic [63:0] b;
    b = '1;
    for (int unsigned j = 0; j < BOUND_COUNT; j++) begin
      if (j == i) begin
        b = BOUND_NS[j];
      end
    end
    return b;
  endfunction

endpackage

FILE: hw/rtl/lbh_classify.sv
// Bucket classifier: compares a sample against every bound in parallel and
// saturates the requested bucket index. Depends on lbh_pkg.
module lbh_classify import lbh_pkg::*; #(
  parameter int unsigned BUCKETS = 12,
  parameter int unsigned IDX_W   = 4
) (
  input  logic [63:0]      latency_ns,
  input  logic [3:0]       bucket_index,
  output logic [IDX_W-1:0] hit,
  output logic [IDX_W-1:0] sel
);

  // First bucket whose bound the sample does not exceed, else overflow.
  always_comb begin
    hit = IDX_W'(BUCKETS - 1);
    for (int i = int'(BUCKETS) - 2; i >= 0; i--) begin
      if (latency_ns <= bound_of(i)) begin
        hit = IDX_W'(i);
      end
    end
  end

  // Out-of-range indexes address the overflow bucket.
  always_comb begin
    if (32'(bucket_index) >= BUCKETS) begin
      sel = IDX_W'(BUCKETS - 1);
    end else begin
      sel = IDX_W'(bucket_index);
    end
  end

endmodule

FILE: hw/rtl/lbh_counter_bank.sv
// Counter bank: raw and cumulative per-bucket counters, latency sum and
// sample count, with the read-out of the addressed bucket. Depends on lbh_pkg.
module lbh_counter_bank import lbh_pkg::*; #(
  parameter int unsigned BUCKETS = 12,
  parameter int unsigned IDX_W   = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  ctl_t             ctl,
  input  logic [63:0]      latency_ns,
  input  logic [IDX_W-1:0] hit,
  input  logic [IDX_W-1:0] sel,
  output logic [63:0]      rd_raw,
  output logic [63:0]      rd_cum,
  output logic [63:0]      rd_sum,
  output logic [63:0]      rd_count
);

  logic [63:0] raw      [BUCKETS];
  logic [63:0] raw_next [BUCKETS];
  logic [63:0] cum      [BUCKETS];
  logic [63:0] cum_next [BUCKETS];
  logic [63:0] sum;
  logic [63:0] sum_next;
  logic [63:0] count;
  logic [63:0] count_next;

  // Observe bumps the hit bucket and every cumulative counter from it up;
  // clear zeroes everything; read leaves the state alone.
  always_comb begin
    for (int k = 0; k < int'(BUCKETS); k++) begin
      raw_next[k] = raw[k];
      cum_next[k] = cum[k];
    end
    sum_next   = sum;
    count_next = count;
    if (ctl.valid) begin
      case (ctl.op)
        OP_OBSERVE: begin
          for (int k = 0; k < int'(BUCKETS); k++) begin
            raw_next[k] = raw[k] + 64'(IDX_W'(k) == hit);
            cum_next[k] = cum[k] + 64'(IDX_W'(k) >= hit);
          end
          sum_next   = sum + latency_ns;
          count_next = count + 64'd1;
        end
        OP_CLEAR: begin
          for (int k = 0; k < int'(BUCKETS); k++) begin
            raw_next[k] = '0;
            cum_next[k] = '0;
          end
          sum_next   = '0;
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // State registers; reset zeroes all counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < int'(BUCKETS); k++) begin
        raw[k] <= '0;
        cum[k] <= '0;
      end
      sum   <= '0;
      count <= '0;
    end else begin
      for (int k = 0; k < int'(BUCKETS); k++) begin
        raw[k] <= raw_next[k];
        cum[k] <= cum_next[k];
      end
      sum   <= sum_next;
      count <= count_next;
    end
  end

  // Results reflect the state after the operation.
  assign rd_raw   = raw_next[sel];
  assign rd_cum   = cum_next[sel];
  assign rd_sum   = sum_next;
  assign rd_count = count_next;

endmodule

FILE: hw/rtl/latency_bucket_histogram_core.sv
// Latency bucket histogram, top level. Depends on lbh_pkg, lbh_classify and
// lbh_counter_bank.
// The result strobe done follows the start beat through the input and result register stages.
// Throughput: one beat per cycle; busy is always low, set by the single
// register stage in front of the parallel counter update.
// Reset: synchronous rst zeroes all counters, the sum and the count at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
module latency_bucket_histogram_core import lbh_pkg::*; #(
  parameter int unsigned BUCKETS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output res_t result
);

  localparam int unsigned IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  logic [IDX_W-1:0] hit_c;
  logic [IDX_W-1:0] sel_c;
  ctl_t             s1_ctl;
  logic [63:0]      s1_ns;
  logic [IDX_W-1:0] s1_hit;
  logic [IDX_W-1:0] s1_sel;
  logic [63:0]      rd_raw;
  logic [63:0]      rd_cum;
  logic [63:0]      rd_sum;
  logic [63:0]      rd_count;
  res_t             result_next;

  // A new beat is taken every cycle.
  assign busy = 1'b0;

  lbh_classify #(
    .BUCKETS (BUCKETS),
    .IDX_W   (IDX_W)
  ) u_classify (
    .latency_ns   (request.latency_ns),
    .bucket_index (request.bucket_index),
    .hit          (hit_c),
    .sel          (sel_c)
  );

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
    end else begin
      s1_ctl.valid <= start && !busy;
    end
    s1_ctl.op <= request.operation;
    s1_ns     <= request.latency_ns;
    s1_hit    <= hit_c;
    s1_sel    <= sel_c;
  end

  lbh_counter_bank #(
    .BUCKETS (BUCKETS),
    .IDX_W   (IDX_W)
  ) u_counter_bank (
    .clk        (clk),
    .rst        (rst),
    .ctl        (s1_ctl),
    .latency_ns (s1_ns),
    .hit        (s1_hit),
    .sel        (s1_sel),
    .rd_raw     (rd_raw),
    .rd_cum     (rd_cum),
    .rd_sum     (rd_sum),
    .rd_count   (rd_count)
  );

  // Assemble the result beat; the hit bucket is reported for observe only.
  always_comb begin
    result_next.bucket_hit       = (s1_ctl.op == OP_OBSERVE) ? 4'(s1_hit) : 4'd0;
    result_next.bucket_count     = rd_raw;
    result_next.cumulative_count = rd_cum;
    result_next.total_sum        = rd_sum;
    result_next.total_count      = rd_count;
  end

  // Result register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
